@@ rtl/tld_pkg.sv @@
// Shared types and constants of the terminal line discipline.
`default_nettype none
package tld_pkg;

   // Result kinds as they leave the block.
   typedef enum logic [2:0] {
      KIND_DATA    = 3'd0,
      KIND_CONSOLE = 3'd1,
      KIND_INTR    = 3'd2,
      KIND_QUIT    = 3'd3,
      KIND_SUSP    = 3'd4
   } kind_type;

   // Request function codes.
   typedef enum logic {
      FUNC_RECEIVE  = 1'b0,
      FUNC_TRANSMIT = 1'b1
   } func_type;

   // Control register indexes.
   typedef enum logic [2:0] {
      CSR_MAP_CR_TO_NL    = 3'd0,
      CSR_SIGNALS_ENABLED = 3'd1,
      CSR_CANONICAL_MODE  = 3'd2,
      CSR_OUTPUT_POST     = 3'd3,
      CSR_EXPAND_NEWLINE  = 3'd4,
      CSR_INTERRUPT_CHAR  = 3'd5,
      CSR_QUIT_CHAR       = 3'd6,
      CSR_SUSPEND_CHAR    = 3'd7
   } csr_index_type;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 8;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_NL = 8'h0A;

   localparam logic [7:0] RESET_INTERRUPT_CHAR = 8'd3;
   localparam logic [7:0] RESET_QUIT_CHAR      = 8'd28;
   localparam logic [7:0] RESET_SUSPEND_CHAR   = 8'd26;

   // One classified word waiting between front and back.
   typedef struct packed {
      kind_type   kind;
      logic [7:0] out_byte;
      logic       line_end;
      logic       expand;    // emit a carriage return ahead of this word
   } q_entry_type;

   // Queue status seen by both sides.
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage
`default_nettype wire

@@ rtl/tld_if.sv @@
// Request and response channel interfaces of the line discipline.
`default_nettype none
interface tld_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] in_byte;

   modport source (output valid, output func, output in_byte, input ready);
   modport sink   (input valid, input func, input in_byte, output ready);
endinterface

interface tld_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [7:0] out_byte;
   logic       line_end;
   logic       last;

   modport source (output valid, output kind, output out_byte, output line_end,
                   output last, input ready);
   modport sink   (input valid, input kind, input out_byte, input line_end,
                   input last, output ready);
endinterface
`default_nettype wire

@@ rtl/tty_line_discipline_core.sv @@
// Top level of the console terminal line discipline.
//
// Terminal line discipline for a console. A receive word (func 0) may have a
// carriage return mapped to newline, is then matched against the interrupt,
// quit and suspend characters (first match in that order wins, a zero
// character never matches, nothing matches with signals disabled) and gives
// either one signal word (byte 0) or one data word, flagged as line end for a
// newline in canonical mode. A transmit word (func 1) gives one console word,
// or a carriage return then a newline when output post-processing and newline
// expansion are both on; last marks the final response word of each request.
// Rate: one request word is accepted every cycle while the queue has room;
// the output register issues one response word per cycle while the response
// side is ready, so an expanded newline occupies it for a carriage return and
// then the newline. A request word passes through the queue write, then the
// output register. QUEUE_DEPTH (at least 2) sets how far the front may run
// ahead of a stalled response side. Control registers are written through the
// csr_ port and take effect on the next accepted word; write them only while the block is idle.
`default_nettype none
module tty_line_discipline_core
   import tld_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
)(
   input  wire                    clock,
   input  wire                    reset,
   tld_req_if.sink                req_chan,
   tld_rsp_if.source              rsp_chan,
   input  wire                    csr_write_en,
   input  wire [CSR_INDEX_W-1:0]  csr_index,
   input  wire [CSR_DATA_W-1:0]   csr_wdata
);

   q_status_type q_status;
   q_entry_type  push_entry;
   q_entry_type  head_entry;
   logic         push;
   logic         pop;

   // Front: hold the control registers, accept and classify request words.
   tld_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .q_status     (q_status),
      .push         (push),
      .push_entry   (push_entry)
   );

   // Decouple intake from the response side.
   tld_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_status   (q_status)
   );

   // Back: expand newlines and drive the response register.
   tld_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule
`default_nettype wire

@@ rtl/tld_front.sv @@
// Front end: control registers, request intake and character classification.
`default_nettype none
module tld_front
   import tld_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,
   tld_req_if.sink                req_chan,
   input  wire                    csr_write_en,
   input  wire [CSR_INDEX_W-1:0]  csr_index,
   input  wire [CSR_DATA_W-1:0]   csr_wdata,
   input  wire q_status_type      q_status,
   output logic                   push,
   output q_entry_type            push_entry
);

   logic       map_cr_to_nl_ff, signals_enabled_ff, canonical_mode_ff;
   logic       output_post_ff, expand_newline_ff;
   logic [7:0] interrupt_char_ff, quit_char_ff, suspend_char_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_cr_to_nl_ff    <= 1'b1;
         signals_enabled_ff <= 1'b1;
         canonical_mode_ff  <= 1'b1;
         output_post_ff     <= 1'b1;
         expand_newline_ff  <= 1'b1;
         interrupt_char_ff  <= RESET_INTERRUPT_CHAR;
         quit_char_ff       <= RESET_QUIT_CHAR;
         suspend_char_ff    <= RESET_SUSPEND_CHAR;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_MAP_CR_TO_NL:    map_cr_to_nl_ff    <= csr_wdata[0];
            CSR_SIGNALS_ENABLED: signals_enabled_ff <= csr_wdata[0];
            CSR_CANONICAL_MODE:  canonical_mode_ff  <= csr_wdata[0];
            CSR_OUTPUT_POST:     output_post_ff     <= csr_wdata[0];
            CSR_EXPAND_NEWLINE:  expand_newline_ff  <= csr_wdata[0];
            CSR_INTERRUPT_CHAR:  interrupt_char_ff  <= csr_wdata;
            CSR_QUIT_CHAR:       quit_char_ff       <= csr_wdata;
            CSR_SUSPEND_CHAR:    suspend_char_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [7:0] rx_char;
   logic       hit_intr, hit_quit, hit_susp;

   always_comb begin
      rx_char = (map_cr_to_nl_ff && req_chan.in_byte == CHAR_CR) ? CHAR_NL
                                                                  : req_chan.in_byte;
      hit_intr = signals_enabled_ff && interrupt_char_ff != 8'd0
                 && interrupt_char_ff == rx_char;
      hit_quit = signals_enabled_ff && quit_char_ff != 8'd0
                 && quit_char_ff == rx_char;
      hit_susp = signals_enabled_ff && suspend_char_ff != 8'd0
                 && suspend_char_ff == rx_char;

      push_entry = '{kind: KIND_DATA, out_byte: 8'd0, line_end: 1'b0, expand: 1'b0};
      if (func_type'(req_chan.func) == FUNC_TRANSMIT) begin
         push_entry.kind     = KIND_CONSOLE;
         push_entry.out_byte = req_chan.in_byte;
         push_entry.expand   = output_post_ff && expand_newline_ff
                               && req_chan.in_byte == CHAR_NL;
      end else if (hit_intr) begin
         push_entry.kind = KIND_INTR;
      end else if (hit_quit) begin
         push_entry.kind = KIND_QUIT;
      end else if (hit_susp) begin
         push_entry.kind = KIND_SUSP;
      end else begin
         push_entry.out_byte = rx_char;
         push_entry.line_end = canonical_mode_ff && rx_char == CHAR_NL;
      end
   end

   assign req_chan.ready = !q_status.full;
   assign push           = req_chan.valid && !q_status.full;

endmodule
`default_nettype wire

@@ rtl/tld_queue.sv @@
// Short queue of classified words between front and back.
`default_nettype none
module tld_queue
   import tld_pkg::*;
#(
   parameter int unsigned DEPTH = 4
)(
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  wire q_entry_type  push_entry,
   input  wire               pop,
   output q_entry_type       head_entry,
   output q_status_type      q_status
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   q_entry_type      mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry     = mem_ff[rd_ptr_ff];
   assign q_status.full  = count_ff == FULL_CNT;
   assign q_status.empty = count_ff == '0;

endmodule
`default_nettype wire

@@ rtl/tld_back.sv @@
// Back end: expands queued words into response words and holds the output register.
`default_nettype none
module tld_back
   import tld_pkg::*;
(
   input  wire                clock,
   input  wire                reset,
   input  wire q_entry_type   head_entry,
   input  wire q_status_type  q_status,
   output logic               pop,
   tld_rsp_if.source          rsp_chan
);

   logic       valid_ff, valid_in;
   logic       cr_sent_ff, cr_sent_in;
   kind_type   kind_ff, kind_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       line_end_ff, line_end_in;
   logic       last_ff, last_in;
   logic       load;

   always_comb begin
      load        = !q_status.empty && (!valid_ff || rsp_chan.ready);
      valid_in    = valid_ff && !rsp_chan.ready;
      cr_sent_in  = cr_sent_ff;
      kind_in     = kind_ff;
      out_byte_in = out_byte_ff;
      line_end_in = line_end_ff;
      last_in     = last_ff;
      pop         = 1'b0;
      if (load) begin
         valid_in    = 1'b1;
         kind_in     = head_entry.kind;
         line_end_in = head_entry.line_end;
         if (head_entry.expand && !cr_sent_ff) begin
            // emit the carriage return first, hold the entry for the newline
            out_byte_in = CHAR_CR;
            last_in     = 1'b0;
            cr_sent_in  = 1'b1;
         end else begin
            out_byte_in = head_entry.out_byte;
            last_in     = 1'b1;
            cr_sent_in  = 1'b0;
            pop         = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         cr_sent_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         cr_sent_ff <= cr_sent_in;
      end
      kind_ff     <= kind_in;
      out_byte_ff <= out_byte_in;
      line_end_ff <= line_end_in;
      last_ff     <= last_in;
   end

   assign rsp_chan.valid    = valid_ff;
   assign rsp_chan.kind     = kind_ff;
   assign rsp_chan.out_byte = out_byte_ff;
   assign rsp_chan.line_end = line_end_ff;
   assign rsp_chan.last     = last_ff;

endmodule
`default_nettype wire
